// ----- rtl/assert_macros.svh -----
// assertion macros shared by the collision block rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define CHK_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cmc_pkg.sv -----
// types, constants and fixed-point helpers for the d2q9 collision block
// no dependencies; used by every rtl module of the block
package cmc_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int WIDE       = 66;
    localparam int DW         = 32 + FRAC_BITS;
    localparam int CMC_QDEPTH = 4;
    localparam int IN_W       = 288;
    localparam int OUT_W      = 360;

    localparam logic signed [WIDE-1:0] SMAX = (WIDE'(1) <<< 31) - WIDE'(1);
    localparam logic signed [WIDE-1:0] SMIN = -(WIDE'(1) <<< 31);
    localparam logic signed [WIDE-1:0] ONE_W = WIDE'(1) <<< FRAC_BITS;
    localparam logic signed [29:0] RELAX_RESET = -30'sd267119286;

    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] d4;
        logic signed [31:0] d5;
    } cmc_sums_t;

    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] d4;
        logic signed [31:0] d5;
        logic               negx;
        logic               negy;
        logic               dz;
    } cmc_side_t;

    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] d4;
        logic signed [31:0] d5;
    } cmc_cell_t;

    typedef struct packed {
        logic [31:0]   rem;
        logic [DW-1:0] x;
    } cmc_dstep_t;

    typedef struct packed {
        logic signed [31:0] rho, ux, uy, d4, d5;
        logic signed [31:0] u2, v2, uv, r1, r2, k3, k8;
        logic signed [31:0] u2v2, u2mv2, u2pv2, ruv, ru2, r1v2;
        logic signed [31:0] ru2mv2, ru2pv2, ru2uy, ru2v2;
        logic signed [31:0] k4a, k5a, r3, k4, k5, r4, r5, s34p, s34m;
        logic signed [31:0] a6, b6, a7, b7, c8, d8, e8, r6, r7, r8;
        logic [8:0][31:0]   p;
        logic               ovs;
    } cmc_bk_t;

    function automatic logic signed [WIDE-1:0] sx(input logic signed [31:0] a);
        return WIDE'(a);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] x);
        if (x > SMAX)
            return 32'(SMAX);
        if (x < SMIN)
            return 32'(SMIN);
        return 32'(x);
    endfunction

    // round to nearest, ties up
    function automatic logic signed [WIDE-1:0] rsh(input logic signed [WIDE-1:0] x,
                                                   input int s);
        return (x + (WIDE'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0]     p;
        logic signed [WIDE-1:0] t;
        p = 64'(a) * 64'(b);
        t = WIDE'(p) + (WIDE'(1) <<< (FRAC_BITS - 1));
        return sat32(t >>> FRAC_BITS);
    endfunction

    // one restoring division step
    function automatic cmc_dstep_t div_step(input logic [31:0] rem,
                                            input logic [DW-1:0] x,
                                            input logic [31:0] d);
        cmc_dstep_t s;
        logic [32:0] r;
        r = {rem, x[DW-1]};
        if (r >= {1'b0, d})
        begin
            s.rem = 32'(r - {1'b0, d});
            s.x   = {x[DW-2:0], 1'b1};
        end
        else
        begin
            s.rem = r[31:0];
            s.x   = {x[DW-2:0], 1'b0};
        end
        return s;
    endfunction

    localparam logic signed [31:0] C23 = sat32(((WIDE'(4) <<< FRAC_BITS) + WIDE'(3)) / 6);
    localparam logic signed [31:0] C19 = sat32(((WIDE'(2) <<< FRAC_BITS) + WIDE'(9)) / 18);

endpackage

// ----- rtl/cmc_div.sv -----
// pipelined restoring divider, two lanes sharing one divisor, one bit per stage
// depends on cmc_pkg
module cmc_div
    import cmc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [31:0]   ud,
    input  logic [31:0]   unx,
    input  logic [31:0]   uny,
    input  cmc_side_t     side_in,
    output logic          out_vld,
    output logic [DW-1:0] qx,
    output logic [DW-1:0] qy,
    output cmc_side_t     side_out
);

    logic [DW-1:0]   vld_reg, vld_next;
    logic [31:0]     rx_reg [0:DW-1];
    logic [31:0]     rx_next [0:DW-1];
    logic [31:0]     ry_reg [0:DW-1];
    logic [31:0]     ry_next [0:DW-1];
    logic [DW-1:0]   xx_reg [0:DW-1];
    logic [DW-1:0]   xx_next [0:DW-1];
    logic [DW-1:0]   xy_reg [0:DW-1];
    logic [DW-1:0]   xy_next [0:DW-1];
    logic [31:0]     ud_reg [0:DW-1];
    logic [31:0]     ud_next [0:DW-1];
    cmc_side_t       sd_reg [0:DW-1];
    cmc_side_t       sd_next [0:DW-1];

    always_comb
    begin
        cmc_dstep_t sa;
        cmc_dstep_t sb;
        sa = div_step('0, {unx, {FRAC_BITS{1'b0}}}, ud);
        sb = div_step('0, {uny, {FRAC_BITS{1'b0}}}, ud);
        rx_next[0] = sa.rem;
        xx_next[0] = sa.x;
        ry_next[0] = sb.rem;
        xy_next[0] = sb.x;
        ud_next[0] = ud;
        sd_next[0] = side_in;
        for (int k = 1; k < DW; k++)
        begin
            sa = div_step(rx_reg[k-1], xx_reg[k-1], ud_reg[k-1]);
            sb = div_step(ry_reg[k-1], xy_reg[k-1], ud_reg[k-1]);
            rx_next[k] = sa.rem;
            xx_next[k] = sa.x;
            ry_next[k] = sb.rem;
            xy_next[k] = sb.x;
            ud_next[k] = ud_reg[k-1];
            sd_next[k] = sd_reg[k-1];
        end
        vld_next = {vld_reg[DW-2:0], in_vld};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DW; k++)
            begin
                rx_reg[k] <= rx_next[k];
                ry_reg[k] <= ry_next[k];
                xx_reg[k] <= xx_next[k];
                xy_reg[k] <= xy_next[k];
                ud_reg[k] <= ud_next[k];
                sd_reg[k] <= sd_next[k];
            end
        end
    end

    assign out_vld  = vld_reg[DW-1];
    assign qx       = xx_reg[DW-1];
    assign qy       = xy_reg[DW-1];
    assign side_out = sd_reg[DW-1];

endmodule

// ----- rtl/cmc_front.sv -----
// front end: takes a cell, forms density, momentum and differences, divides
// depends on cmc_pkg, cmc_div and assert_macros.svh
`include "assert_macros.svh"
module cmc_front
    import cmc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            q_full,
    output logic            push,
    output cmc_cell_t       cell_out
);

    logic               en;
    logic signed [31:0] f [0:8];
    cmc_sums_t          sums;
    logic               acc_vld_reg;
    cmc_sums_t          acc_reg;
    logic               abs_vld_reg;
    logic [31:0]        ud_reg, unx_reg, uny_reg;
    cmc_side_t          side_reg;
    logic               div_vld;
    logic [DW-1:0]      qx, qy;
    cmc_side_t          side_out;
    logic               fin_vld_reg;
    cmc_cell_t          fin_reg, fin_next;

    // the whole front moves together; it halts only when its last word can't leave
    assign en       = !fin_vld_reg || !q_full;
    assign s_tready = en;
    assign push     = fin_vld_reg && !q_full;
    assign cell_out = fin_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            f[i] = s_tdata[32*i +: 32];
        sums.rho = sat32(sx(f[0]) + sx(f[1]) + sx(f[2]) + sx(f[3]) + sx(f[4])
                         + sx(f[5]) + sx(f[6]) + sx(f[7]) + sx(f[8]));
        sums.mx  = sat32(sx(f[1]) - sx(f[3]) + sx(f[5]) - sx(f[6]) - sx(f[7]) + sx(f[8]));
        sums.my  = sat32(sx(f[2]) - sx(f[4]) + sx(f[5]) + sx(f[6]) - sx(f[7]) - sx(f[8]));
        sums.d4  = sat32(sx(f[1]) - sx(f[2]) + sx(f[3]) - sx(f[4]));
        sums.d5  = sat32(sx(f[5]) - sx(f[6]) + sx(f[7]) - sx(f[8]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= 1'b0;
            abs_vld_reg <= 1'b0;
            fin_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            acc_vld_reg <= s_tvalid;
            abs_vld_reg <= acc_vld_reg;
            fin_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg       <= sums;
            ud_reg        <= acc_reg.rho[31] ? 32'(-sx(acc_reg.rho)) : acc_reg.rho;
            unx_reg       <= acc_reg.mx[31] ? 32'(-sx(acc_reg.mx)) : acc_reg.mx;
            uny_reg       <= acc_reg.my[31] ? 32'(-sx(acc_reg.my)) : acc_reg.my;
            side_reg.rho  <= acc_reg.rho;
            side_reg.d4   <= acc_reg.d4;
            side_reg.d5   <= acc_reg.d5;
            side_reg.negx <= acc_reg.mx[31] != acc_reg.rho[31];
            side_reg.negy <= acc_reg.my[31] != acc_reg.rho[31];
            side_reg.dz   <= acc_reg.rho == '0;
            fin_reg       <= fin_next;
        end
    end

    cmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (abs_vld_reg),
        .ud       (ud_reg),
        .unx      (unx_reg),
        .uny      (uny_reg),
        .side_in  (side_reg),
        .out_vld  (div_vld),
        .qx       (qx),
        .qy       (qy),
        .side_out (side_out)
    );

    // sign and signed saturation of the unsigned quotients; zero velocity when the density is zero
    always_comb
    begin
        fin_next.rho = side_out.rho;
        fin_next.d4  = side_out.d4;
        fin_next.d5  = side_out.d5;
        if (side_out.dz)
            fin_next.ux = '0;
        else if (side_out.negx)
            fin_next.ux = (qx >= (DW'(1) << 31)) ? 32'h8000_0000 : 32'(32'd0 - qx[31:0]);
        else
            fin_next.ux = (qx > DW'(32'h7fff_ffff)) ? 32'h7fff_ffff : qx[31:0];
        if (side_out.dz)
            fin_next.uy = '0;
        else if (side_out.negy)
            fin_next.uy = (qy >= (DW'(1) << 31)) ? 32'h8000_0000 : 32'(32'd0 - qy[31:0]);
        else
            fin_next.uy = (qy > DW'(32'h7fff_ffff)) ? 32'h7fff_ffff : qy[31:0];
    end

    `CHK_NEXT(a_fin_hold, fin_vld_reg && q_full, fin_vld_reg && $stable(fin_reg), "front result lost while queue full")

endmodule

// ----- rtl/cmc_fifo.sv -----
// short queue between the front end and the collision back end
// depends on cmc_pkg and assert_macros.svh
`include "assert_macros.svh"
module cmc_fifo
    import cmc_pkg::*;
#(
    parameter int DEPTH = CMC_QDEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmc_cell_t wdata,
    output logic      full,
    input  logic      pop,
    output cmc_cell_t rdata,
    output logic      empty
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmc_cell_t        mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    `CHK_ALWAYS(a_cnt_max, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `CHK_NEXT(a_cnt_up, push && !pop, count_reg == CNT_W'($past(count_reg) + 1'b1), "queue count missed a push")
    `CHK_NEXT(a_cnt_dn, pop && !push, count_reg == CNT_W'($past(count_reg) - 1'b1), "queue count missed a pop")

endmodule

// ----- rtl/cmc_back.sv -----
// back end: moment relaxation and mapping back to populations, nine stages
// depends on cmc_pkg
module cmc_back
    import cmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic signed [29:0] relax,
    input  logic              q_empty,
    input  cmc_cell_t         q_data,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int NB = 9;

    logic            en;
    logic [NB:1]     vld_reg, vld_next;
    cmc_bk_t         bk_reg [1:NB];
    cmc_bk_t         bk_next [1:NB];
    logic signed [31:0] rf;

    assign en  = !vld_reg[NB] || m_tready;
    assign pop = en && !q_empty;
    assign rf  = 32'(relax);

    always_comb
    begin
        cmc_bk_t t;
        vld_next = {vld_reg[NB-1:1], !q_empty};

        // products of velocity and density
        t     = '0;
        t.rho = q_data.rho;
        t.ux  = q_data.ux;
        t.uy  = q_data.uy;
        t.d4  = q_data.d4;
        t.d5  = q_data.d5;
        t.u2  = qmul(q_data.ux, q_data.ux);
        t.v2  = qmul(q_data.uy, q_data.uy);
        t.uv  = qmul(q_data.ux, q_data.uy);
        t.r1  = qmul(q_data.rho, q_data.ux);
        t.r2  = qmul(q_data.rho, q_data.uy);
        t.k3  = qmul(q_data.rho, C23);
        t.k8  = qmul(q_data.rho, C19);
        bk_next[1] = t;

        t       = bk_reg[1];
        t.u2v2  = qmul(t.u2, t.v2);
        t.u2mv2 = sat32(sx(t.u2) - sx(t.v2));
        t.u2pv2 = sat32(sx(t.u2) + sx(t.v2));
        t.ruv   = qmul(t.rho, t.uv);
        t.ru2   = qmul(t.rho, t.u2);
        t.r1v2  = qmul(t.r1, t.v2);
        bk_next[2] = t;

        t        = bk_reg[2];
        t.ru2mv2 = qmul(t.rho, t.u2mv2);
        t.ru2pv2 = qmul(t.rho, t.u2pv2);
        t.ru2uy  = qmul(t.ru2, t.uy);
        t.ru2v2  = qmul(t.rho, t.u2v2);
        bk_next[3] = t;

        // shear central moments before relaxation
        t     = bk_reg[3];
        t.k4a = sat32(sx(t.d4) - sx(t.ru2mv2));
        t.k5a = sat32(sx(t.d5) - sx(t.ruv));
        t.r3  = sat32(sx(t.k3) + sx(t.ru2pv2));
        bk_next[4] = t;

        t    = bk_reg[4];
        t.k4 = qmul(rf, t.k4a);
        t.k5 = qmul(rf, t.k5a);
        bk_next[5] = t;

        t      = bk_reg[5];
        t.r4   = sat32(sx(t.k4) + sx(t.ru2mv2));
        t.r5   = sat32(sx(t.k5) + sx(t.ruv));
        t.s34p = sat32(sx(t.k3) + sx(t.k4));
        t.s34m = sat32(sx(t.k3) - sx(t.k4));
        bk_next[6] = t;

        t    = bk_reg[6];
        t.a6 = qmul(t.ux, t.k5);
        t.b6 = qmul(t.uy, t.s34p);
        t.a7 = qmul(t.ux, t.s34m);
        t.b7 = qmul(t.uy, t.k5);
        t.c8 = qmul(t.k3, t.u2pv2);
        t.d8 = qmul(t.k4, t.u2mv2);
        t.e8 = qmul(t.uv, t.k5);
        bk_next[7] = t;

        // third and fourth order raw moments
        t    = bk_reg[7];
        t.r6 = sat32(sx(sat32(sx(t.a6) <<< 1)) + rsh(sx(t.b6), 1) + sx(t.ru2uy));
        t.r7 = sat32(rsh(sx(t.a7), 1) + sx(sat32(sx(t.b7) <<< 1)) + sx(t.r1v2));
        t.r8 = sat32(sx(t.k8) + rsh(sx(t.c8), 1) - rsh(sx(t.d8), 1) + sx(t.ru2v2)
                     + sx(sat32(sx(t.e8) <<< 2)));
        bk_next[8] = t;

        t      = bk_reg[8];
        t.p[0] = sat32(sx(t.rho) - sx(t.r3) + sx(t.r8));
        t.p[1] = sat32(rsh(sx(t.r1) - sx(t.r7) - sx(t.r8), 1) + rsh(sx(t.r3) + sx(t.r4), 2));
        t.p[2] = sat32(rsh(sx(t.r2) - sx(t.r6) - sx(t.r8), 1) + rsh(sx(t.r3) - sx(t.r4), 2));
        t.p[3] = sat32(rsh(sx(t.r3) + sx(t.r4), 2) + rsh(-sx(t.r1) + sx(t.r7) - sx(t.r8), 1));
        t.p[4] = sat32(rsh(sx(t.r3) - sx(t.r4), 2) + rsh(-sx(t.r2) + sx(t.r6) - sx(t.r8), 1));
        t.p[5] = sat32(rsh(sx(t.r5) + sx(t.r6) + sx(t.r7) + sx(t.r8), 2));
        t.p[6] = sat32(rsh(sx(t.r6) - sx(t.r5) - sx(t.r7) + sx(t.r8), 2));
        t.p[7] = sat32(rsh(sx(t.r5) - sx(t.r6) - sx(t.r7) + sx(t.r8), 2));
        t.p[8] = sat32(rsh(sx(t.r7) - sx(t.r6) - sx(t.r5) + sx(t.r8), 2));
        t.ovs  = (sx(t.ux) > ONE_W) || (sx(t.ux) < -ONE_W);
        bk_next[9] = t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= NB; k++)
                bk_reg[k] <= bk_next[k];
        end
    end

    assign m_tvalid = vld_reg[NB];
    assign m_tdata  = {7'd0, bk_reg[NB].ovs, bk_reg[NB].uy, bk_reg[NB].ux, bk_reg[NB].p};

endmodule

// ----- rtl/d2q9_central_moment_collision.sv -----
// top level of the d2q9 central-moment collision block
// depends on cmc_pkg, cmc_front, cmc_fifo and cmc_back
//
// Input stream s_*: one lattice cell per word, nine Q4.28 populations.
// Output stream m_*: nine post-collision populations, cell velocity and the
// over-speed flag, one word per input word, in input order.
// Configuration: cfg_we writes cfg_wdata into the relaxation factor; write
// only while no cell is in flight.
// Throughput: one cell per cycle while m_tready does not stall the output.
// The velocity divider resolves one quotient bit per stage over
// 32 + FRAC_BITS stages for the Q4.28 velocities.
// The front end (sums and divider) and the back end (collision, nine stages)
// are joined by a four-word queue; a stalled m_tready halts only the back
// end, and s_tready falls once the queue is full and the front end's last
// stage holds a word.
// Reset clears all valid flags and the queue and loads the default
// relaxation factor; no input word is lost or doubled across a stall.
module d2q9_central_moment_collision
    import cmc_pkg::*;
#(
    parameter int FIFO_DEPTH = CMC_QDEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // pop_rest, pop_east, pop_north, pop_west, pop_south, pop_northeast,
    // pop_northwest, pop_southwest, pop_southeast
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // post_rest .. post_southeast, vel_x, vel_y, over_speed, zero pad
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_we,
    input  logic [29:0]      cfg_wdata
);

    logic signed [29:0] relax_reg;
    logic               push, pop, q_full, q_empty;
    cmc_cell_t          q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            relax_reg <= RELAX_RESET;
        else if (cfg_we)
            relax_reg <= cfg_wdata;
    end

    cmc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .cell_out (q_wdata)
    );

    cmc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    cmc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .relax    (relax_reg),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
